// File: rtl/core/cpc_pkg.sv
// Shared types and constants for the candlestick pattern classifier.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package cpc_pkg;

    localparam int PRICE_BITS  = 32;
    localparam int CODE_BITS   = 4;
    localparam int IN_FIELDS   = 4;
    localparam int IN_TDATA_W  = ((IN_FIELDS * PRICE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((CODE_BITS + 7) / 8) * 8;

    typedef logic [PRICE_BITS-1:0] price_t;
    typedef logic [CODE_BITS-1:0]  code_t;

    // Pattern codes, in priority order.
    localparam code_t PAT_NONE           = 4'd0;
    localparam code_t PAT_HAMMER         = 4'd1;
    localparam code_t PAT_INV_HAMMER     = 4'd2;
    localparam code_t PAT_HANGING_MAN    = 4'd3;
    localparam code_t PAT_SHOOTING_STAR  = 4'd4;
    localparam code_t PAT_BULL_ENGULFING = 4'd5;
    localparam code_t PAT_BEAR_ENGULFING = 4'd6;
    localparam code_t PAT_BULL_HARAMI    = 4'd7;
    localparam code_t PAT_BEAR_HARAMI    = 4'd8;
    localparam code_t PAT_BULL_KICKER    = 4'd9;
    localparam code_t PAT_BEAR_KICKER    = 4'd10;

    typedef struct packed {
        price_t open_price;
        price_t high_price;
        price_t low_price;
        price_t close_price;
    } candle_t;

    // Derived sizes of one candle.
    typedef struct packed {
        price_t body;
        price_t wick;
        price_t tail;
        price_t top;
        price_t bot;
        logic   bull;
        logic   bear;
    } feat_t;

endpackage

`default_nettype wire

// File: rtl/core/cpc_candle.sv
// Derives body, upper wick, lower tail and direction of one candle.
// Depends on cpc_pkg.
`default_nettype none

module cpc_candle (
    input  wire cpc_pkg::candle_t candle,
    output cpc_pkg::feat_t        feat
);
    import cpc_pkg::*;

    logic   bull;
    price_t top;
    price_t bot;

    assign bull = candle.close_price > candle.open_price;
    assign top  = bull ? candle.close_price : candle.open_price;
    assign bot  = bull ? candle.open_price  : candle.close_price;

    always_comb begin
        feat.bull = bull;
        feat.bear = candle.close_price < candle.open_price;
        feat.top  = top;
        feat.bot  = bot;
        feat.body = top - bot;
        // Inconsistent prices saturate the shadows at zero.
        feat.wick = (candle.high_price > top) ? candle.high_price - top : '0;
        feat.tail = (bot > candle.low_price) ? bot - candle.low_price : '0;
    end

endmodule

`default_nettype wire

// File: rtl/core/cpc_classify.sv
// Priority encoder over the single- and two-candle pattern tests.
// Depends on cpc_pkg.
`default_nettype none

module cpc_classify (
    input  wire cpc_pkg::feat_t cur,
    input  wire cpc_pkg::price_t prev_open,
    input  wire cpc_pkg::price_t prev_close,
    output cpc_pkg::code_t       code
);
    import cpc_pkg::*;

    logic   prv_bull;
    logic   prv_bear;
    price_t ptop;
    price_t pbot;
    price_t pbody;
    logic   hammer;
    logic   inv_hammer;
    logic   gap_up;
    logic   gap_down;
    logic   up_turn;
    logic   down_turn;

    assign prv_bull = prev_close > prev_open;
    assign prv_bear = prev_close < prev_open;
    assign ptop     = prv_bull ? prev_close : prev_open;
    assign pbot     = prv_bull ? prev_open  : prev_close;
    assign pbody    = ptop - pbot;

    // Twice the body needs one extra bit, so both sides are widened.
    assign hammer     = ({1'b0, cur.tail} > {cur.body, 1'b0}) && (cur.wick < cur.body);
    assign inv_hammer = ({1'b0, cur.wick} > {cur.body, 1'b0}) && (cur.tail < cur.body);

    assign gap_up    = ptop < cur.bot;
    assign gap_down  = cur.top < pbot;
    assign up_turn   = prv_bear && cur.bull;
    assign down_turn = prv_bull && cur.bear;

    always_comb begin
        if (cur.bull && hammer) begin
            code = PAT_HAMMER;
        end else if (cur.bear && inv_hammer) begin
            code = PAT_INV_HAMMER;
        end else if (down_turn && gap_up && hammer) begin
            code = PAT_HANGING_MAN;
        end else if (down_turn && gap_up && inv_hammer) begin
            code = PAT_SHOOTING_STAR;
        end else if (up_turn && (pbody < cur.body)) begin
            code = PAT_BULL_ENGULFING;
        end else if (down_turn && (pbody < cur.body)) begin
            code = PAT_BEAR_ENGULFING;
        end else if (up_turn && (cur.body < pbody)) begin
            code = PAT_BULL_HARAMI;
        end else if (down_turn && (cur.body < pbody)) begin
            code = PAT_BEAR_HARAMI;
        end else if (up_turn && gap_up) begin
            code = PAT_BULL_KICKER;
        end else if (down_turn && gap_down) begin
            code = PAT_BEAR_KICKER;
        end else begin
            code = PAT_NONE;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/candlestick_pattern_classifier.sv
// Candlestick pattern classifier: input register, pattern logic, result register.
// Depends on cpc_pkg, cpc_candle and cpc_classify.
//
// Usage:
//   The slave channel (s_tvalid/s_tready/s_tdata) takes one candle per
//   transfer: open, high, low and close prices packed from the lowest bit up.
//   The master channel (m_tvalid/m_tready/m_tdata) returns exactly one
//   pattern code per candle, in order. Code 0 means no pattern.
//   After its transfer the candle is held in the input register while the
//   pattern logic works on it; m_tvalid rises when the code is loaded into
//   the result register.
//   Throughput is one candle per cycle while m_tready stays high;
//   the pair of registers lets a new candle in while a result is waiting.
//   The previous candle's open and close are kept internally and update as
//   each candle moves into the result register.
//   When the receiver stalls, the result register holds and the input
//   register fills; s_tready then drops until the result is taken.
//   Reset (aresetn low at a clock edge) empties both registers and clears
//   the stored candle to zero, so the first candle after reset can only
//   match a single-candle pattern.
`default_nettype none

module candlestick_pattern_classifier (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // open_price, high_price, low_price, close_price
    input  wire [cpc_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // pattern_code, zero padded
    output logic [cpc_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import cpc_pkg::*;

    logic    in_valid_reg;
    logic    in_valid_next;
    candle_t in_candle_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    code_t   out_code_reg;
    price_t  prev_open_reg;
    price_t  prev_close_reg;

    logic    out_en;
    logic    advance;
    logic    s_take;
    candle_t s_candle;
    feat_t   cur_feat;
    code_t   code;

    assign s_candle.open_price  = s_tdata[PRICE_BITS-1:0];
    assign s_candle.high_price  = s_tdata[2*PRICE_BITS-1:PRICE_BITS];
    assign s_candle.low_price   = s_tdata[3*PRICE_BITS-1:2*PRICE_BITS];
    assign s_candle.close_price = s_tdata[4*PRICE_BITS-1:3*PRICE_BITS];

    assign out_en   = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_en;
    assign s_tready = !in_valid_reg || out_en;
    assign s_take   = s_tvalid && s_tready;

    assign in_valid_next  = s_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    cpc_candle u_candle (
        .candle (in_candle_reg),
        .feat   (cur_feat)
    );

    cpc_classify u_classify (
        .cur        (cur_feat),
        .prev_open  (prev_open_reg),
        .prev_close (prev_close_reg),
        .code       (code)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            prev_open_reg  <= '0;
            prev_close_reg <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                prev_open_reg  <= in_candle_reg.open_price;
                prev_close_reg <= in_candle_reg.close_price;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_candle_reg <= s_candle;
        end
        if (advance) begin
            out_code_reg <= code;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-CODE_BITS){1'b0}}, out_code_reg};

endmodule

`default_nettype wire

// File: tb/sv/candlestick_pattern_classifier_checker.sv
// Scoreboard for the candlestick pattern classifier: watches both stream channels,
// predicts the pattern code of every accepted candle and compares the results.
// Depends on cpc_pkg for the price width and the pattern codes.
`timescale 1ns / 100ps

module candlestick_pattern_classifier_checker (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    input  wire                              s_tready,
    // open_price, high_price, low_price, close_price
    input  wire [cpc_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  wire                              m_tvalid,
    input  wire                              m_tready,
    // pattern_code, zero padded
    input  wire [cpc_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output int                               error_count,
    output int                               codes_outstanding
);
    import cpc_pkg::*;

    localparam int PB = PRICE_BITS;

    code_t  expected_codes[$];
    price_t last_open;
    price_t last_close;

    // Classifies one candle against the stored open and close. All sizes are kept
    // in 64 bits so that doubling a full-range body cannot wrap.
    function automatic code_t classify_candle(price_t o, price_t h, price_t l, price_t c,
                                              price_t po, price_t pc);
        logic [63:0] o6, h6, l6, c6, po6, pc6;
        logic [63:0] top, bot, body, wick, tail, pbody, ptop, pbot;
        logic        cur_bull, cur_bear, prv_bull, prv_bear;
        logic        gap_up, gap_down, up_turn, down_turn, hammer, inv_hammer;
        o6    = 64'(o);
        h6    = 64'(h);
        l6    = 64'(l);
        c6    = 64'(c);
        po6   = 64'(po);
        pc6   = 64'(pc);
        top   = (o6 > c6) ? o6 : c6;
        bot   = (o6 < c6) ? o6 : c6;
        body  = top - bot;
        wick  = (h6 > top) ? h6 - top : 64'd0;
        tail  = (bot > l6) ? bot - l6 : 64'd0;
        ptop  = (po6 > pc6) ? po6 : pc6;
        pbot  = (po6 < pc6) ? po6 : pc6;
        pbody = ptop - pbot;
        cur_bull   = c6 > o6;
        cur_bear   = c6 < o6;
        prv_bull   = pc6 > po6;
        prv_bear   = pc6 < po6;
        gap_up     = ptop < bot;
        gap_down   = top < pbot;
        up_turn    = prv_bear && cur_bull;
        down_turn  = prv_bull && cur_bear;
        hammer     = (tail > (body << 1)) && (wick < body);
        inv_hammer = (wick > (body << 1)) && (tail < body);
        if (cur_bull && hammer)                     return PAT_HAMMER;
        if (cur_bear && inv_hammer)                 return PAT_INV_HAMMER;
        if (down_turn && gap_up && hammer)          return PAT_HANGING_MAN;
        if (down_turn && gap_up && inv_hammer)      return PAT_SHOOTING_STAR;
        if (up_turn && pbody < body)                return PAT_BULL_ENGULFING;
        if (down_turn && pbody < body)              return PAT_BEAR_ENGULFING;
        if (up_turn && body < pbody)                return PAT_BULL_HARAMI;
        if (down_turn && body < pbody)              return PAT_BEAR_HARAMI;
        if (up_turn && gap_up)                      return PAT_BULL_KICKER;
        if (down_turn && gap_down)                  return PAT_BEAR_KICKER;
        return PAT_NONE;
    endfunction

    always @(posedge aclk) begin
        code_t  want;
        price_t o, h, l, c;
        if (!aresetn) begin
            expected_codes.delete();
            last_open         <= '0;
            last_close        <= '0;
            error_count       <= 0;
            codes_outstanding <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_codes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %0d",
                             $time, m_tdata);
                    error_count <= error_count + 1;
                end else begin
                    want = expected_codes.pop_front();
                    if (m_tdata[CODE_BITS-1:0] !== want) begin
                        $display("%0t: pattern code mismatch, expected %0d, got %0d",
                                 $time, want, m_tdata[CODE_BITS-1:0]);
                        error_count <= error_count + 1;
                    end else if (m_tdata[OUT_TDATA_W-1:CODE_BITS] !== '0) begin
                        $display("%0t: padding mismatch, expected 0, got %0h",
                                 $time, m_tdata[OUT_TDATA_W-1:CODE_BITS]);
                        error_count <= error_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                o = s_tdata[0*PB +: PB];
                h = s_tdata[1*PB +: PB];
                l = s_tdata[2*PB +: PB];
                c = s_tdata[3*PB +: PB];
                expected_codes.push_back(classify_candle(o, h, l, c, last_open, last_close));
                last_open  <= o;
                last_close <= c;
            end
            codes_outstanding <= expected_codes.size();
        end
    end

endmodule

// File: tb/sv/candlestick_pattern_classifier_test.sv
// Top of the candlestick pattern classifier testbench: clock, reset, candle stimulus,
// receiver stalls, watchdog and verdict.
// Depends on cpc_pkg, the classifier RTL and candlestick_pattern_classifier_checker.
`timescale 1ns / 100ps

module candlestick_pattern_classifier_test;
    import cpc_pkg::*;

    localparam int IDLE_LIMIT     = 2000;
    localparam int ITEMS_PER_PASS = 216;
    localparam price_t PMAX       = '1;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int     error_count;
    int     codes_outstanding;
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     quiet_cycles   = 0;
    price_t level          = 32'd1000;
    longint last_body      = 0;

    int sender_plan[5]   = '{0, 80, 0, 31, 0};
    int receiver_plan[5] = '{0, 0, 80, 31, 0};

    always #5 aclk = ~aclk;

    candlestick_pattern_classifier i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    candlestick_pattern_classifier_checker i_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .error_count       (error_count),
        .codes_outstanding (codes_outstanding)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Ends the run when neither channel has moved a transfer for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_candle(price_t o, price_t h, price_t l, price_t c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c, l, h, o};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Holds the sender off until every candle sent so far has its result back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (codes_outstanding != 0) @(posedge aclk);
    endtask

    function automatic price_t clamp_price(longint v);
        if (v < 0) return '0;
        if (v > longint'(PMAX)) return PMAX;
        return price_t'(v);
    endfunction

    // Mostly candles built around a drifting price level, so that gaps, body
    // comparisons and shadow ratios land on both sides; the rest is raw noise.
    task automatic send_random_candle();
        longint unit, body, wick, tail, o, c, hi, lo, delta;
        int     pick;
        pick = $urandom_range(99);
        if (pick < 12) begin
            send_candle($urandom, $urandom, $urandom, $urandom);
        end else begin
            if ($urandom_range(19) == 0) begin
                case ($urandom_range(2))
                    0:       level = $urandom;
                    1:       level = $urandom_range(0, 50);
                    default: level = PMAX - $urandom_range(0, 50);
                endcase
            end
            unit = 1 + ($urandom & ((longint'(1) << $urandom_range(0, 20)) - 1));
            if ($urandom_range(4) == 0)
                body = last_body;
            else
                body = unit * $urandom_range(0, 3);
            wick  = unit * $urandom_range(0, 8) + $urandom_range(0, 1);
            tail  = unit * $urandom_range(0, 8) + $urandom_range(0, 1);
            delta = unit * $urandom_range(0, 6);
            o = $urandom_range(1) ? longint'(level) + delta : longint'(level) - delta;
            c = $urandom_range(1) ? o + body : o - body;
            hi = ((o > c) ? o : c) + wick;
            lo = ((o < c) ? o : c) - tail;
            last_body = body;
            level = clamp_price(c);
            send_candle(clamp_price(o), clamp_price(hi), clamp_price(lo), level);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // First candle is bullish, but the cleared store cannot form a pair.
        send_candle(32'd10, 32'd20, 32'd10, 32'd20);
        send_candle('0, '0, '0, '0);
        send_candle(PMAX, PMAX, PMAX, PMAX);
        // Full-range bodies, where doubling the body needs a 33rd bit.
        send_candle('0, PMAX, '0, PMAX);
        send_candle(PMAX, PMAX, '0, '0);
        send_candle(32'd100, 32'd112, 32'd50, 32'd110);    // hammer
        send_candle(32'd110, 32'd150, 32'd98, 32'd100);    // inverted hammer
        send_candle(32'd50, 32'd60, 32'd50, 32'd60);
        send_candle(32'd110, 32'd112, 32'd50, 32'd100);    // hanging man
        send_candle(32'd50, 32'd60, 32'd50, 32'd60);
        send_candle(32'd110, 32'd150, 32'd98, 32'd100);    // shooting star shape, hidden
        send_candle(32'd60, 32'd60, 32'd50, 32'd50);
        send_candle(32'd45, 32'd70, 32'd45, 32'd70);       // bullish engulfing
        send_candle(32'd80, 32'd80, 32'd40, 32'd40);       // bearish engulfing
        send_candle(32'd50, 32'd60, 32'd50, 32'd60);       // bullish harami
        send_candle(32'd58, 32'd58, 32'd55, 32'd55);       // bearish harami
        send_candle(32'd100, 32'd103, 32'd100, 32'd103);   // bullish kicker, equal bodies
        send_candle(32'd50, 32'd50, 32'd47, 32'd47);       // bearish kicker
        send_candle(32'd48, 32'd51, 32'd48, 32'd51);       // equal bodies, no gap
        send_candle(32'd70, 32'd90, 32'd10, 32'd70);       // doji
        // High below the body and low above it: both shadows clip to zero.
        send_candle(32'd100, 32'd10, 32'd4000, 32'd200);
        send_candle(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        send_candle(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        drain_results();

        for (int pass = 0; pass < 5; pass++) begin
            send_idle_pct  = sender_plan[pass];
            recv_stall_pct = receiver_plan[pass];
            for (int n = 0; n < ITEMS_PER_PASS; n++) send_random_candle();
            drain_results();
        end

        recv_stall_pct = 0;
        repeat (4) @(posedge aclk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
